// ===== rtl/ncs_pkg.sv =====
package ncs_pkg;

  // Store geometry and arithmetic widths
  localparam int MAX_CENTERS    = 16;
  localparam int MAX_DIMS       = 256;
  localparam int ELEM_BITS      = 16;
  localparam int SLOT_BITS      = 4;
  localparam int DIM_BITS       = 8;
  localparam int COUNT_BITS     = 5;
  localparam int ADDR_BITS      = SLOT_BITS + DIM_BITS;
  localparam int STORE_DEPTH    = MAX_CENTERS * MAX_DIMS;
  localparam int DIFF_BITS      = ELEM_BITS + 1;
  localparam int SQ_BITS        = 2 * DIFF_BITS;
  localparam int DIST_BITS      = 40;

  // Queue between front and back
  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_PTR_BITS = 1;
  localparam int QUEUE_CNT_BITS = 2;

  // Request type codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // One classified item as it travels through the queue
  typedef struct packed {
    logic                        is_query;
    logic                        write_ok;
    logic                        dim_ok;
    logic [SLOT_BITS-1:0]        slot;
    logic [DIM_BITS-1:0]         dim;
    logic signed [ELEM_BITS-1:0] value;
    logic                        last;
  } ncs_op_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    B_IDLE,
    B_ISSUE,
    B_DRAIN
  } ncs_bstate_t;

endpackage

// ===== rtl/nearest_center_search_core.sv =====
// Nearest-centre search by squared distance over a store of centre vectors.
// Loads are taken back to back; the back end takes no new item while a query
// element is still passing through the single store read port and squarer.
// The result strobe is registered from the squarer stage of the last element,
// after the store read; the receiver cannot stall.
// Reset clears the running sums, the queue and sets active_centers to 1.
module nearest_center_search_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [ncs_pkg::COUNT_BITS-1:0]       cfg_data,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 req_type,
  input  logic [ncs_pkg::SLOT_BITS-1:0]        center_slot,
  input  logic [ncs_pkg::DIM_BITS-1:0]         dim_index,
  input  logic signed [ncs_pkg::ELEM_BITS-1:0] elem_value,
  input  logic                                 last_elem,
  output logic                                 done,
  output logic [ncs_pkg::SLOT_BITS-1:0]        nearest_index,
  output logic [ncs_pkg::DIST_BITS-1:0]        nearest_distance
);

  logic [ncs_pkg::COUNT_BITS-1:0] active_centers;
  logic [ncs_pkg::SLOT_BITS-1:0]  last_center;
  logic                           push;
  logic                           pop;
  logic                           q_empty;
  logic                           q_full;
  ncs_pkg::ncs_op_t               push_op;
  ncs_pkg::ncs_op_t               head_op;

  // Hold the active centre count
  always_ff @(posedge clk) begin
    if (rst) begin
      active_centers <= ncs_pkg::COUNT_BITS'(1);
    end else if (cfg_we) begin
      active_centers <= cfg_data;
    end
  end

  // Clamp the count into range and turn it into the final centre index
  always_comb begin
    if (active_centers == '0) begin
      last_center = '0;
    end else if (active_centers > ncs_pkg::COUNT_BITS'(ncs_pkg::MAX_CENTERS)) begin
      last_center = ncs_pkg::SLOT_BITS'(ncs_pkg::MAX_CENTERS - 1);
    end else begin
      last_center = ncs_pkg::SLOT_BITS'(active_centers - 1'b1);
    end
  end

  ncs_front u_front (
    .start       (start),
    .req_type    (req_type),
    .center_slot (center_slot),
    .dim_index   (dim_index),
    .elem_value  (elem_value),
    .last_elem   (last_elem),
    .q_full      (q_full),
    .busy        (busy),
    .push        (push),
    .push_op     (push_op)
  );

  ncs_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .empty   (q_empty),
    .full    (q_full)
  );

  ncs_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_empty          (q_empty),
    .q_op             (head_op),
    .last_center      (last_center),
    .pop              (pop),
    .done             (done),
    .nearest_index    (nearest_index),
    .nearest_distance (nearest_distance)
  );

endmodule

// ===== rtl/ncs_front.sv =====
module ncs_front (
  input  logic                                start,
  input  logic                                req_type,
  input  logic [ncs_pkg::SLOT_BITS-1:0]       center_slot,
  input  logic [ncs_pkg::DIM_BITS-1:0]        dim_index,
  input  logic signed [ncs_pkg::ELEM_BITS-1:0] elem_value,
  input  logic                                last_elem,
  input  logic                                q_full,
  output logic                                busy,
  output logic                                push,
  output ncs_pkg::ncs_op_t                    push_op
);

  logic dim_ok;
  logic slot_ok;

  // Range checks against the store geometry
  assign dim_ok  = ({1'b0, dim_index} < (ncs_pkg::DIM_BITS + 1)'(ncs_pkg::MAX_DIMS));
  assign slot_ok = ({1'b0, center_slot} < (ncs_pkg::SLOT_BITS + 1)'(ncs_pkg::MAX_CENTERS));

  // Hold off new items while the queue is full
  assign busy = q_full;
  assign push = start && !q_full;

  // Classify the item for the back end
  always_comb begin
    push_op          = '0;
    push_op.is_query = (req_type == ncs_pkg::REQ_QUERY);
    push_op.write_ok = (req_type == ncs_pkg::REQ_LOAD) && dim_ok && slot_ok;
    push_op.dim_ok   = dim_ok;
    push_op.slot     = center_slot;
    push_op.dim      = dim_index;
    push_op.value    = elem_value;
    push_op.last     = last_elem && (req_type == ncs_pkg::REQ_QUERY);
  end

endmodule

// ===== rtl/ncs_queue.sv =====
module ncs_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ncs_pkg::ncs_op_t push_op,
  input  logic             pop,
  output ncs_pkg::ncs_op_t head_op,
  output logic             empty,
  output logic             full
);

  ncs_pkg::ncs_op_t                     entries [ncs_pkg::QUEUE_DEPTH];
  logic [ncs_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr;
  logic [ncs_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr;
  logic [ncs_pkg::QUEUE_CNT_BITS-1:0]   count;

  assign empty   = (count == '0);
  assign full    = (count == ncs_pkg::QUEUE_CNT_BITS'(ncs_pkg::QUEUE_DEPTH));
  assign head_op = entries[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/ncs_back.sv =====
module ncs_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_empty,
  input  ncs_pkg::ncs_op_t                     q_op,
  input  logic [ncs_pkg::SLOT_BITS-1:0]        last_center,
  output logic                                 pop,
  output logic                                 done,
  output logic [ncs_pkg::SLOT_BITS-1:0]        nearest_index,
  output logic [ncs_pkg::DIST_BITS-1:0]        nearest_distance
);

  ncs_pkg::ncs_bstate_t state;
  ncs_pkg::ncs_bstate_t state_next;
  logic                 issue;

  // Center element store
  logic [ncs_pkg::ELEM_BITS-1:0] mem [ncs_pkg::STORE_DEPTH];

  // Query being worked on
  logic signed [ncs_pkg::ELEM_BITS-1:0] q_feat;
  logic [ncs_pkg::DIM_BITS-1:0]         q_dim;
  logic                                 q_last;
  logic                                 q_dim_ok;
  logic [ncs_pkg::SLOT_BITS-1:0]        c_issue;

  // Pipeline stages
  logic                                 s1_valid;
  logic                                 s1_tail;
  logic [ncs_pkg::SLOT_BITS-1:0]        s1_center;
  logic [ncs_pkg::ELEM_BITS-1:0]        rd_data;
  logic                                 s2_valid;
  logic                                 s2_tail;
  logic [ncs_pkg::SLOT_BITS-1:0]        s2_center;
  logic [ncs_pkg::SQ_BITS-1:0]          s2_sq;

  logic signed [ncs_pkg::DIFF_BITS-1:0] diff;
  logic signed [ncs_pkg::SQ_BITS-1:0]   sq;

  // Running sums and best so far
  logic [ncs_pkg::DIST_BITS-1:0] partial [ncs_pkg::MAX_CENTERS];
  logic [ncs_pkg::DIST_BITS:0]   sum_wide;
  logic [ncs_pkg::DIST_BITS-1:0] sum;
  logic [ncs_pkg::DIST_BITS-1:0] best_dist;
  logic [ncs_pkg::SLOT_BITS-1:0] best_idx;
  logic                          take_new;

  // Sequence one item: a load straight from idle, a query over all active centers
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    issue      = 1'b0;
    case (state)
      ncs_pkg::B_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (q_op.is_query) begin
            state_next = ncs_pkg::B_ISSUE;
          end
        end
      end
      ncs_pkg::B_ISSUE: begin
        issue = 1'b1;
        if (c_issue == last_center) begin
          state_next = ncs_pkg::B_DRAIN;
        end
      end
      ncs_pkg::B_DRAIN: begin
        if (s2_valid && s2_tail) begin
          state_next = ncs_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = ncs_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ncs_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the query and step the center counter
  always_ff @(posedge clk) begin
    if (pop && q_op.is_query) begin
      q_feat   <= q_op.value;
      q_dim    <= q_op.dim;
      q_last   <= q_op.last;
      q_dim_ok <= q_op.dim_ok;
      c_issue  <= '0;
    end else if (issue) begin
      c_issue  <= c_issue + 1'b1;
    end
  end

  // Write center elements from loads
  always_ff @(posedge clk) begin
    if (pop && !q_op.is_query && q_op.write_ok) begin
      mem[{q_op.slot, q_op.dim}] <= q_op.value;
    end
  end

  // Read one center element per cycle
  always_ff @(posedge clk) begin
    rd_data <= mem[{c_issue, q_dim}];
  end

  // Square the difference
  assign diff = $signed({q_feat[ncs_pkg::ELEM_BITS-1], q_feat})
              - $signed({rd_data[ncs_pkg::ELEM_BITS-1], rd_data});
  assign sq   = ncs_pkg::SQ_BITS'(diff * diff);

  always_ff @(posedge clk) begin
    s1_center <= c_issue;
    s1_tail   <= (c_issue == last_center);
    s2_center <= s1_center;
    s2_tail   <= s1_tail;
    s2_sq     <= sq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  // Accumulate, saturating at the top of the sum range, and compare
  assign sum_wide = {1'b0, partial[s2_center]}
                  + (q_dim_ok ? (ncs_pkg::DIST_BITS + 1)'(s2_sq) : '0);
  assign sum      = sum_wide[ncs_pkg::DIST_BITS] ? '1 : sum_wide[ncs_pkg::DIST_BITS-1:0];
  assign take_new = (s2_center == '0) || (sum < best_dist);

  // Clear every running sum once the last element of a vector is done
  always_ff @(posedge clk) begin
    if (rst || (s2_valid && s2_tail && q_last)) begin
      for (int i = 0; i < ncs_pkg::MAX_CENTERS; i++) begin
        partial[i] <= '0;
      end
    end else if (s2_valid) begin
      partial[s2_center] <= q_last ? '0 : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && q_last && take_new) begin
      best_idx  <= s2_center;
      best_dist <= sum;
    end
  end

  // Present the result for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_valid && s2_tail && q_last;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s2_tail && q_last) begin
      nearest_index    <= take_new ? s2_center : best_idx;
      nearest_distance <= take_new ? sum : best_dist;
    end
  end

endmodule
